// File: design/hvd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hvd_pkg
// Shared widths, constants and elaboration-time helpers for the haversine
// distance pipeline and its checker.
// ----------------------------------------------------------------------------
package hvd_pkg;

    // field widths
    localparam int LAT_W  = 28;
    localparam int LON_W  = 29;
    localparam int DIST_W = 21;

    // configuration port
    localparam int PDATA_W  = 32;
    localparam int PADDR_W  = 3;
    localparam int ADDR_LSB = 2;

    typedef enum logic {
        REG_REF_LAT = 1'b0,
        REG_REF_LON = 1'b1
    } cfg_reg_t;

    localparam logic signed [LAT_W-1:0] REF_LAT_RST = -28'sd37810592;
    localparam logic signed [LON_W-1:0] REF_LON_RST = 29'sd144963123;

    // pipeline shape
    localparam int CORDIC_ITER_DEF = 32;
    localparam int LAT_FIXED       = 42;
    localparam int NLANES          = 4;
    localparam int SQRT_STEPS      = 31;

    // internal widths
    localparam int ARG_W  = 31;
    localparam int M_W    = 28;
    localparam int RAD_W  = 32;
    localparam int PROD_W = M_W + RAD_W;
    localparam int X_W    = 34;
    localparam int Z_W    = 33;
    localparam int SC_W   = 32;
    localparam int SQ_W   = 64;
    localparam int REM_W  = 61;
    localparam int T_W    = 63;
    localparam int ROOT_W = 31;
    localparam int ANG_W  = 32;
    localparam int DP_W   = ANG_W + DIST_W;

    // angle units are half micro-degrees
    localparam logic signed [ARG_W-1:0] FULL_TURN    = 31'sd720000000;
    localparam logic signed [ARG_W-1:0] HALF_TURN    = 31'sd360000000;
    localparam logic signed [ARG_W-1:0] QUARTER_TURN = 31'sd180000000;

    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
    localparam logic [RAD_W-1:0] RAD_PER_UNIT_Q58 =
        RAD_W'((PI_Q60 + 64'd720000000) / 64'd1440000000);

    localparam logic [REM_W-1:0] ONE_Q60 = {1'b1, 60'b0};

    localparam logic [DIST_W-1:0] TWO_RADIUS_CENTIKM = 21'd1274200;
    localparam logic [DIST_W-1:0] MAX_DIST           = 21'd2001509;

    // q30 rounding of atan(2^-i)
    function automatic longint atan_q30(input int i);
        longint v;
        case (i)
            0:       v = 64'sd843314857;
            1:       v = 64'sd497837829;
            2:       v = 64'sd263043837;
            3:       v = 64'sd133525159;
            4:       v = 64'sd67021687;
            5:       v = 64'sd33543516;
            6:       v = 64'sd16775851;
            7:       v = 64'sd8388437;
            8:       v = 64'sd4194283;
            9:       v = 64'sd2097149;
            10:      v = 64'sd1048576;
            default:
            begin
                if (i <= 31)
                    v = ((longint'(1) << (60 - i)) + (longint'(1) << 29)) >>> 30;
                else
                    v = 0;
            end
        endcase
        return v;
    endfunction

    // q30 magnitude after rotating (1, 0) by angle zero
    function automatic longint cordic_gain(input int n);
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        int     i;
        x = longint'(1) << 30;
        y = 0;
        z = 0;
        for (i = 0; i < 48; i++)
        begin
            if (i < n)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0)
                begin
                    x = x - ys;
                    y = y + xs;
                    z = z - atan_q30(i);
                end
                else
                begin
                    x = x + ys;
                    y = y - xs;
                    z = z + atan_q30(i);
                end
            end
        end
        if (x < 1)
            x = 1;
        return x;
    endfunction

endpackage

// File: design/haversine_distance_to_reference.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// haversine_distance_to_reference
// Great-circle distance from a point to a configured reference point.
// ----------------------------------------------------------------------------
// Usage:
//   Points enter on start with lat_microdeg / lon_microdeg; an item is taken
//   whenever start is high and busy is low. busy stays low, so a new point
//   may enter in every clock cycle.
//   Each point gives one distance_centikm, shown for one cycle with done.
//   The pipeline holds the two CORDIC chains (one stage per iteration) and
//   the 31-stage square root between registered front and back stages;
//   throughput is one item per cycle.
//   The reference point sits in two APB registers: ref_lat_microdeg at
//   address 0 and ref_lon_microdeg at address 4; write them while no item
//   is in flight. pready is always high.
//   Reset loads the reference registers with their default point and drops
//   all items in flight. The receiver cannot stall: results are not held.
// ----------------------------------------------------------------------------
module haversine_distance_to_reference #(
    parameter int CORDIC_ITERATIONS = hvd_pkg::CORDIC_ITER_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [hvd_pkg::PADDR_W-1:0]        paddr,
    input  logic [hvd_pkg::PDATA_W-1:0]        pwdata,
    output logic [hvd_pkg::PDATA_W-1:0]        prdata,
    output logic                               pready,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [hvd_pkg::LAT_W-1:0]   lat_microdeg,
    input  logic signed [hvd_pkg::LON_W-1:0]   lon_microdeg,
    output logic                               done,
    output logic [hvd_pkg::DIST_W-1:0]         distance_centikm
);
    import hvd_pkg::*;

    localparam int     NIT      = CORDIC_ITERATIONS;
    localparam int     LATENCY  = 2 * NIT + LAT_FIXED;
    localparam longint GAIN     = cordic_gain(NIT);
    localparam longint INV_GAIN = ((longint'(1) << 60) + GAIN / 2) / GAIN;
    localparam logic signed [X_W-1:0] INIT_X = X_W'(INV_GAIN);

    // configuration registers
    logic signed [LAT_W-1:0] ref_lat_reg;
    logic signed [LON_W-1:0] ref_lon_reg;
    logic                    cfg_wr;
    cfg_reg_t                cfg_sel;

    // pipeline valid bits
    logic [LATENCY-1:0] vld_reg;
    logic [LATENCY-1:0] vld_next;
    logic               accept;

    // front end
    logic signed [ARG_W-1:0]  arg_reg   [NLANES];
    logic [M_W-1:0]           m_reg     [NLANES];
    logic                     rneg_b_reg[NLANES];
    logic                     fneg_b_reg[NLANES];
    logic [PROD_W-1:0]        prod_reg  [NLANES];
    logic                     rneg_c_reg[NLANES];
    logic                     fneg_c_reg[NLANES];
    logic signed [Z_W-1:0]    z0_reg    [NLANES];
    logic                     fneg_d_reg[NLANES];

    // rotation chains
    logic signed [X_W-1:0]    rx_reg[NIT][NLANES];
    logic signed [X_W-1:0]    ry_reg[NIT][NLANES];
    logic signed [Z_W-1:0]    rz_reg[NIT][NLANES];
    logic                     rf_reg[NIT][NLANES];

    // haversine term
    logic signed [SC_W-1:0]   sc_reg[NLANES];
    logic signed [SQ_W-1:0]   sq1_reg;
    logic signed [SQ_W-1:0]   sq2_reg;
    logic signed [SQ_W-1:0]   cc_reg;
    logic signed [SQ_W-1:0]   s1sq_m2_reg;
    logic signed [SC_W-1:0]   q_reg;
    logic signed [SC_W-1:0]   t_reg;
    logic signed [SQ_W-1:0]   s1sq_m3_reg;
    logic signed [SQ_W-1:0]   qt_reg;
    logic signed [SQ_W-1:0]   a_sum;
    logic [REM_W-1:0]         a_next;
    logic [REM_W-1:0]         a_reg;
    logic [REM_W-1:0]         b_reg;

    // square roots, lane 0 of a and lane 1 of 1 - a
    logic [REM_W-1:0]         rem_reg [SQRT_STEPS][2];
    logic [ROOT_W-1:0]        root_reg[SQRT_STEPS][2];

    // vectoring chain
    logic signed [X_W-1:0]    vx_reg[NIT];
    logic signed [X_W-1:0]    vy_reg[NIT];
    logic signed [Z_W-1:0]    vz_reg[NIT];

    // distance scaling
    logic [ANG_W-1:0]         ang_u;
    logic [DP_W-1:0]          dprod_reg;
    logic [DP_W:0]            dsum;
    logic [DP_W-30:0]         d_full;
    logic [DIST_W-1:0]        dist_next;
    logic [DIST_W-1:0]        dist_reg;

    genvar gl;
    genvar gi;

    // apb register file
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_sel = cfg_reg_t'(paddr[ADDR_LSB]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_lat_reg <= REF_LAT_RST;
            ref_lon_reg <= REF_LON_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_sel)
                REG_REF_LAT: ref_lat_reg <= pwdata[LAT_W-1:0];
                REG_REF_LON: ref_lon_reg <= pwdata[LON_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_sel)
            REG_REF_LAT: prdata = PDATA_W'(ref_lat_reg);
            REG_REF_LON: prdata = PDATA_W'(ref_lon_reg);
            default:     prdata = '0;
        endcase
    end

    // item handshake and valid chain
    assign busy     = 1'b0;
    assign accept   = start & ~busy;
    assign vld_next = {vld_reg[LATENCY-2:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    // half-angle and latitude arguments in half micro-degrees
    always_ff @(posedge clk)
    begin
        arg_reg[0] <= ARG_W'(lat_microdeg) - ARG_W'(ref_lat_reg);
        arg_reg[1] <= ARG_W'(lon_microdeg) - ARG_W'(ref_lon_reg);
        arg_reg[2] <= ARG_W'(ref_lat_reg) + ARG_W'(ref_lat_reg);
        arg_reg[3] <= ARG_W'(lat_microdeg) + ARG_W'(lat_microdeg);
    end

    for (gl = 0; gl < NLANES; gl++)
    begin : g_lane
        logic signed [ARG_W-1:0] r1;
        logic signed [ARG_W-1:0] r2;
        logic signed [ARG_W-1:0] rabs;
        logic                    fold;
        logic [PROD_W:0]         rsum;
        logic signed [Z_W-1:0]   rad_mag;

        // reduce to one turn, then fold into a quarter turn
        always_comb
        begin
            if (arg_reg[gl] > HALF_TURN)
                r1 = arg_reg[gl] - FULL_TURN;
            else if (arg_reg[gl] <= -HALF_TURN)
                r1 = arg_reg[gl] + FULL_TURN;
            else
                r1 = arg_reg[gl];
            fold = 1'b0;
            r2   = r1;
            if (r1 > QUARTER_TURN)
            begin
                r2   = r1 - HALF_TURN;
                fold = 1'b1;
            end
            else if (r1 < -QUARTER_TURN)
            begin
                r2   = r1 + HALF_TURN;
                fold = 1'b1;
            end
            rabs = r2[ARG_W-1] ? -r2 : r2;
        end

        always_ff @(posedge clk)
        begin
            m_reg[gl]      <= rabs[M_W-1:0];
            rneg_b_reg[gl] <= r2[ARG_W-1];
            fneg_b_reg[gl] <= fold;
        end

        // degrees to radians
        always_ff @(posedge clk)
        begin
            prod_reg[gl]   <= PROD_W'(m_reg[gl]) * PROD_W'(RAD_PER_UNIT_Q58);
            rneg_c_reg[gl] <= rneg_b_reg[gl];
            fneg_c_reg[gl] <= fneg_b_reg[gl];
        end

        assign rsum    = (PROD_W+1)'(prod_reg[gl]) + (PROD_W+1)'(1 << 27);
        assign rad_mag = Z_W'(rsum >> 28);

        always_ff @(posedge clk)
        begin
            z0_reg[gl]     <= rneg_c_reg[gl] ? -rad_mag : rad_mag;
            fneg_d_reg[gl] <= fneg_c_reg[gl];
        end

        // rotation, one iteration per stage
        for (gi = 0; gi < NIT; gi++)
        begin : g_rot
            localparam logic signed [Z_W-1:0] ATAN = Z_W'(atan_q30(gi));
            logic signed [X_W-1:0] x_in;
            logic signed [X_W-1:0] y_in;
            logic signed [Z_W-1:0] z_in;
            logic                  f_in;
            logic signed [X_W-1:0] x_next;
            logic signed [X_W-1:0] y_next;
            logic signed [Z_W-1:0] z_next;

            if (gi == 0)
            begin : g_first
                assign x_in = INIT_X;
                assign y_in = '0;
                assign z_in = z0_reg[gl];
                assign f_in = fneg_d_reg[gl];
            end
            else
            begin : g_next
                assign x_in = rx_reg[gi-1][gl];
                assign y_in = ry_reg[gi-1][gl];
                assign z_in = rz_reg[gi-1][gl];
                assign f_in = rf_reg[gi-1][gl];
            end

            always_comb
            begin
                if (!z_in[Z_W-1])
                begin
                    x_next = x_in - (y_in >>> gi);
                    y_next = y_in + (x_in >>> gi);
                    z_next = z_in - ATAN;
                end
                else
                begin
                    x_next = x_in + (y_in >>> gi);
                    y_next = y_in - (x_in >>> gi);
                    z_next = z_in + ATAN;
                end
            end

            always_ff @(posedge clk)
            begin
                rx_reg[gi][gl] <= x_next;
                ry_reg[gi][gl] <= y_next;
                rz_reg[gi][gl] <= z_next;
                rf_reg[gi][gl] <= f_in;
            end
        end

        // sines on the half-angle lanes, cosines on the latitude lanes
        if (gl < 2)
        begin : g_sin
            always_ff @(posedge clk)
            begin
                sc_reg[gl] <= rf_reg[NIT-1][gl] ? SC_W'(-ry_reg[NIT-1][gl])
                                                : SC_W'(ry_reg[NIT-1][gl]);
            end
        end
        else
        begin : g_cos
            always_ff @(posedge clk)
            begin
                sc_reg[gl] <= rf_reg[NIT-1][gl] ? SC_W'(-rx_reg[NIT-1][gl])
                                                : SC_W'(rx_reg[NIT-1][gl]);
            end
        end
    end

    // squares and cosine product
    always_ff @(posedge clk)
    begin
        sq1_reg <= SQ_W'(sc_reg[0]) * SQ_W'(sc_reg[0]);
        sq2_reg <= SQ_W'(sc_reg[1]) * SQ_W'(sc_reg[1]);
        cc_reg  <= SQ_W'(sc_reg[2]) * SQ_W'(sc_reg[3]);
    end

    // rounded back to q30
    always_ff @(posedge clk)
    begin
        q_reg       <= SC_W'((cc_reg + (SQ_W'(1) <<< 29)) >>> 30);
        t_reg       <= SC_W'((sq2_reg + (SQ_W'(1) <<< 29)) >>> 30);
        s1sq_m2_reg <= sq1_reg;
    end

    always_ff @(posedge clk)
    begin
        qt_reg      <= SQ_W'(q_reg) * SQ_W'(t_reg);
        s1sq_m3_reg <= s1sq_m2_reg;
    end

    // haversine term, clamped to [0, 1]
    assign a_sum = s1sq_m3_reg + qt_reg;

    always_comb
    begin
        if (a_sum[SQ_W-1])
            a_next = '0;
        else if (a_sum > SQ_W'(ONE_Q60))
            a_next = ONE_Q60;
        else
            a_next = a_sum[REM_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= ONE_Q60 - a_next;
    end

    // digit-by-digit square roots, one root bit per stage
    for (gl = 0; gl < 2; gl++)
    begin : g_sq
        for (gi = 0; gi < SQRT_STEPS; gi++)
        begin : g_step
            localparam int BITPOS = SQRT_STEPS - 1 - gi;
            logic [REM_W-1:0]  rem_in;
            logic [ROOT_W-1:0] root_in;
            logic [T_W-1:0]    trial;
            logic [REM_W-1:0]  rem_next;
            logic [ROOT_W-1:0] root_next;

            if (gi == 0)
            begin : g_first
                assign rem_in  = (gl == 0) ? a_reg : b_reg;
                assign root_in = '0;
            end
            else
            begin : g_next
                assign rem_in  = rem_reg[gi-1][gl];
                assign root_in = root_reg[gi-1][gl];
            end

            assign trial = (T_W'(root_in) << (BITPOS + 1)) | (T_W'(1) << (2 * BITPOS));

            always_comb
            begin
                if (T_W'(rem_in) >= trial)
                begin
                    rem_next  = REM_W'(T_W'(rem_in) - trial);
                    root_next = root_in | (ROOT_W'(1) << BITPOS);
                end
                else
                begin
                    rem_next  = rem_in;
                    root_next = root_in;
                end
            end

            always_ff @(posedge clk)
            begin
                rem_reg[gi][gl]  <= rem_next;
                root_reg[gi][gl] <= root_next;
            end
        end
    end

    // atan2 by vectoring, one iteration per stage
    for (gi = 0; gi < NIT; gi++)
    begin : g_vec
        localparam logic signed [Z_W-1:0] ATAN = Z_W'(atan_q30(gi));
        logic signed [X_W-1:0] x_in;
        logic signed [X_W-1:0] y_in;
        logic signed [Z_W-1:0] z_in;
        logic signed [X_W-1:0] x_next;
        logic signed [X_W-1:0] y_next;
        logic signed [Z_W-1:0] z_next;

        if (gi == 0)
        begin : g_first
            assign x_in = X_W'(root_reg[SQRT_STEPS-1][1]);
            assign y_in = X_W'(root_reg[SQRT_STEPS-1][0]);
            assign z_in = '0;
        end
        else
        begin : g_next
            assign x_in = vx_reg[gi-1];
            assign y_in = vy_reg[gi-1];
            assign z_in = vz_reg[gi-1];
        end

        always_comb
        begin
            if (!y_in[X_W-1])
            begin
                x_next = x_in + (y_in >>> gi);
                y_next = y_in - (x_in >>> gi);
                z_next = z_in + ATAN;
            end
            else
            begin
                x_next = x_in - (y_in >>> gi);
                y_next = y_in + (x_in >>> gi);
                z_next = z_in - ATAN;
            end
        end

        always_ff @(posedge clk)
        begin
            vx_reg[gi] <= x_next;
            vy_reg[gi] <= y_next;
            vz_reg[gi] <= z_next;
        end
    end

    // half the central angle times twice the radius
    assign ang_u = vz_reg[NIT-1][Z_W-1] ? '0 : vz_reg[NIT-1][ANG_W-1:0];

    always_ff @(posedge clk)
    begin
        dprod_reg <= DP_W'(ang_u) * DP_W'(TWO_RADIUS_CENTIKM);
    end

    // round to centikm and saturate
    assign dsum   = (DP_W+1)'(dprod_reg) + (DP_W+1)'(1 << 29);
    assign d_full = dsum[DP_W:30];

    always_comb
    begin
        if (d_full > (DP_W-29)'(MAX_DIST))
            dist_next = MAX_DIST;
        else
            dist_next = d_full[DIST_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        dist_reg <= dist_next;
    end

    assign done             = vld_reg[LATENCY-1];
    assign distance_centikm = dist_reg;

endmodule

// File: design/hvd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hvd_checker
// Port-level checks of item timing, result range and register-port wait states, bound to the top level.
// ----------------------------------------------------------------------------
module hvd_checker #(
    parameter int CORDIC_ITERATIONS = hvd_pkg::CORDIC_ITER_DEF
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        psel,
    input logic                        pready,
    input logic                        start,
    input logic                        busy,
    input logic                        done,
    input logic [hvd_pkg::DIST_W-1:0]  distance_centikm
);
    import hvd_pkg::*;

    localparam int LATENCY = 2 * CORDIC_ITERATIONS + LAT_FIXED;

    // every result traces back to an item taken a fixed time earlier
    a_done_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without a matching item");

    // every item gives its result after the fixed latency
    a_item_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("item lost in the pipeline");

    // distance saturates at half the circumference
    a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (distance_centikm <= MAX_DIST))
        else $error("distance above saturation limit");

    // register port never inserts wait states
    a_no_wait: assert property (@(posedge clk) disable iff (!rst_n)
        psel |-> pready)
        else $error("pready low during access");

endmodule

bind haversine_distance_to_reference hvd_checker #(
    .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
) u_hvd_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .pready           (pready),
    .start            (start),
    .busy             (busy),
    .done             (done),
    .distance_centikm (distance_centikm)
);
